// ===== hw/rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and decode helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Default depth of the group queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CTL_FF    = 8'h0C;
  localparam logic [7:0] CTL_LF    = 8'h0A;
  localparam logic [7:0] CTL_CR    = 8'h0D;
  localparam logic [7:0] CTL_TAB   = 8'h09;

  // Last position of the hex group (four bytes after backslash-u)
  localparam logic [1:0] HEX_LAST_POS = 2'd3;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_end;
  } out_req_t;

  // Bytes produced by one input request; cnt of zero with last set is an end marker
  typedef struct packed {
    logic            last;
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
  } grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
  } utf8_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.val = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.val = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic utf8_t utf8_encode(input logic [15:0] v);
    utf8_t u;
    u.cnt   = 2'd0;
    u.bytes = '0;
    if (v == 16'd0) begin
      u.cnt = 2'd0;
    end else if (v < 16'h0080) begin
      u.cnt      = 2'd1;
      u.bytes[0] = v[7:0];
    end else if (v < 16'h0800) begin
      u.cnt      = 2'd2;
      u.bytes[0] = {3'b110, v[10:6]};
      u.bytes[1] = {2'b10, v[5:0]};
    end else begin
      u.cnt      = 2'd3;
      u.bytes[0] = {4'b1110, v[15:12]};
      u.bytes[1] = {2'b10, v[11:6]};
      u.bytes[2] = {2'b10, v[5:0]};
    end
    return u;
  endfunction

endpackage

// ===== hw/rtl/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front
// Accepts escaped bytes, tracks escape state and classifies each request
// into a group of zero to three output bytes for the queue.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  in_req_t in_data,
  input  q_stat_t q_stat,
  output logic    push,
  output grp_t    push_grp
);

  mode_t       mode_r, mode_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] hex_val_r, hex_val_nxt;
  logic        hex_stop_r, hex_stop_nxt;
  logic        accept;
  grp_t        grp;
  hex_t        hd;
  utf8_t       u8;
  logic [15:0] val_upd;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // Decode the byte against the current escape state
  always_comb begin
    mode_nxt     = mode_r;
    hex_cnt_nxt  = hex_cnt_r;
    hex_val_nxt  = hex_val_r;
    hex_stop_nxt = hex_stop_r;
    grp          = '0;
    grp.last     = in_data.in_last;
    hd           = hex_digit(in_data.in_byte);
    val_upd      = (!hex_stop_r && hd.ok) ? {hex_val_r[11:0], hd.val} : hex_val_r;
    u8           = utf8_encode(val_upd);
    case (mode_r)
      MODE_ESCAPE: begin
        if (in_data.in_byte == CH_U) begin
          mode_nxt     = MODE_HEX;
          hex_cnt_nxt  = 2'd0;
          hex_val_nxt  = 16'd0;
          hex_stop_nxt = 1'b0;
        end else begin
          mode_nxt = MODE_NORMAL;
          grp.cnt  = 2'd1;
          case (in_data.in_byte)
            CH_QUOTE:  grp.bytes[0] = CH_QUOTE;
            CH_BSLASH: grp.bytes[0] = CH_BSLASH;
            CH_SLASH:  grp.bytes[0] = CH_SLASH;
            CH_B:      grp.bytes[0] = CTL_BS;
            CH_F:      grp.bytes[0] = CTL_FF;
            CH_N:      grp.bytes[0] = CTL_LF;
            CH_R:      grp.bytes[0] = CTL_CR;
            CH_T:      grp.bytes[0] = CTL_TAB;
            default:   grp.cnt      = 2'd0;
          endcase
        end
      end
      MODE_HEX: begin
        hex_val_nxt  = val_upd;
        hex_stop_nxt = hex_stop_r || !hd.ok;
        if (hex_cnt_r == HEX_LAST_POS) begin
          grp.cnt      = u8.cnt;
          grp.bytes    = u8.bytes;
          mode_nxt     = MODE_NORMAL;
          hex_cnt_nxt  = 2'd0;
          hex_val_nxt  = 16'd0;
          hex_stop_nxt = 1'b0;
        end else begin
          hex_cnt_nxt = hex_cnt_r + 2'd1;
        end
      end
      default: begin
        if (in_data.in_byte == CH_BSLASH) begin
          mode_nxt = MODE_ESCAPE;
        end else begin
          grp.cnt      = 2'd1;
          grp.bytes[0] = in_data.in_byte;
        end
      end
    endcase
    // Drop any open escape at the end of a string
    if (in_data.in_last) begin
      mode_nxt     = MODE_NORMAL;
      hex_cnt_nxt  = 2'd0;
      hex_val_nxt  = 16'd0;
      hex_stop_nxt = 1'b0;
    end
  end

  assign push     = accept && (grp.cnt != 2'd0 || grp.last);
  assign push_grp = grp;

  // Advance escape state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_NORMAL;
      hex_cnt_r  <= 2'd0;
      hex_val_r  <= 16'd0;
      hex_stop_r <= 1'b0;
    end else if (accept) begin
      mode_r     <= mode_nxt;
      hex_cnt_r  <= hex_cnt_nxt;
      hex_val_r  <= hex_val_nxt;
      hex_stop_r <= hex_stop_nxt;
    end
  end

endmodule

// ===== hw/rtl/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_queue
// Short FIFO of byte groups between the front and the back.
// ----------------------------------------------------------------------------
module jsu_queue import jsu_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  grp_t    push_grp,
  input  logic    pop,
  output grp_t    head,
  output q_stat_t q_stat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  grp_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == CNT_MAX);
  assign q_stat.empty = (cnt_r == '0);

  // Store pushed groups
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_MAX) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_MAX) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back
// Splits queued groups into single result requests, one per cycle while
// out_ready is high, through an output register.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  grp_t     head,
  input  q_stat_t  q_stat,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data
);

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r;
  out_req_t   out_data_r, item;
  logic [1:0] last_idx;
  logic       load;

  // Pick the current byte of the head group
  always_comb begin
    last_idx        = (head.cnt == 2'd0) ? 2'd0 : head.cnt - 2'd1;
    item.out_byte   = (head.cnt == 2'd0) ? 8'd0 : head.bytes[idx_r];
    item.byte_valid = (head.cnt != 2'd0);
    item.string_end = head.last && (idx_r == last_idx);
    load            = (!out_valid_r || out_ready) && !q_stat.empty;
    pop             = load && (idx_r == last_idx);
    idx_nxt         = pop ? 2'd0 : idx_r + 2'd1;
  end

  // Hold the result until taken, refill from the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r <= idx_nxt;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/json_string_unescape.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape
// Streaming unescaper for the bytes of a JSON string value.
// ----------------------------------------------------------------------------
// One escaped byte is taken per cycle whenever the group queue has room; each
// byte turns into zero to three unescaped bytes (backslash-u sends its value
// as UTF-8), and the result side sends one byte per cycle from its output
// register while out_ready is high. A byte that yields nothing gives no result,
// except the last byte of a string, which then gives one end marker with
// byte_valid low. When idle, a result passes the queue memory, then the output
// register. The output rate of one request per cycle while out_ready is high
// sets sustained throughput; the queue of QDEPTH groups absorbs multi-byte bursts.
module json_string_unescape import jsu_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data
);

  logic    push, pop;
  grp_t    push_grp, head;
  q_stat_t q_stat;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_grp (push_grp)
  );

  jsu_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // An end marker without a byte only closes a string
  a_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |-> out_data.string_end)
    else $error("result without byte is not a string end");

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("group pushed into full queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("group popped from empty queue");

endmodule

// ===== verif/tb_json_string_unescape.sv =====
// ----------------------------------------------------------------------------
// tb_json_string_unescape
// Self-checking bench for the JSON string unescaper. Drives escaped strings
// (directed corner cases, then random well-formed and broken escapes, plus
// raw noise) with bursty input and a stalling receiver, predicts every
// unescaped byte and end marker, and compares each result request in order.
// ----------------------------------------------------------------------------
module tb_json_string_unescape;
  import jsu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Tracks the unescape state and holds the bytes still owed by the block
  class unescape_checker;
    mode_t      mode;
    logic [1:0] hex_pos;
    logic [15:0] hex_acc;
    bit         hex_halt;
    out_req_t   expected_bytes[$];
    int         errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      mode     = MODE_NORMAL;
      hex_pos  = '0;
      hex_acc  = '0;
      hex_halt = 1'b0;
    endfunction

    function void note_request(in_req_t req);
      logic [7:0] c;
      logic [7:0] plain[$];
      logic [15:0] v;
      int         nib;
      out_req_t   e;
      c   = req.in_byte;
      nib = -1;
      case (mode)
        MODE_ESCAPE: begin
          if (c == CH_U) begin
            clear();
            mode = MODE_HEX;
          end else begin
            // map known escape letters, drop anything else
            case (c)
              CH_QUOTE, CH_BSLASH, CH_SLASH: plain.push_back(c);
              CH_B: plain.push_back(CTL_BS);
              CH_F: plain.push_back(CTL_FF);
              CH_N: plain.push_back(CTL_LF);
              CH_R: plain.push_back(CTL_CR);
              CH_T: plain.push_back(CTL_TAB);
              default: ;
            endcase
            mode = MODE_NORMAL;
          end
        end
        MODE_HEX: begin
          if (c >= "0" && c <= "9") nib = int'(c) - int'("0");
          else if (c >= "a" && c <= "f") nib = int'(c) - int'("a") + 10;
          else if (c >= "A" && c <= "F") nib = int'(c) - int'("A") + 10;
          // accumulate digits until the first non-hex byte
          if (!hex_halt && nib >= 0) hex_acc = {hex_acc[11:0], 4'(nib)};
          else hex_halt = 1'b1;
          if (hex_pos == HEX_LAST_POS) begin
            v = hex_acc;
            if (v == 16'd0) begin
              // nothing to send
            end else if (v < 16'h0080) begin
              plain.push_back(v[7:0]);
            end else if (v < 16'h0800) begin
              plain.push_back({3'b110, v[10:6]});
              plain.push_back({2'b10, v[5:0]});
            end else begin
              plain.push_back({4'b1110, v[15:12]});
              plain.push_back({2'b10, v[11:6]});
              plain.push_back({2'b10, v[5:0]});
            end
            clear();
          end else begin
            hex_pos++;
          end
        end
        default: begin
          if (c == CH_BSLASH) mode = MODE_ESCAPE;
          else plain.push_back(c);
        end
      endcase
      // end marker when the last byte yields nothing
      if (req.in_last && plain.size() == 0) begin
        e.out_byte   = '0;
        e.byte_valid = 1'b0;
        e.string_end = 1'b1;
        expected_bytes.push_back(e);
      end
      foreach (plain[k]) begin
        e.out_byte   = plain[k];
        e.byte_valid = 1'b1;
        e.string_end = req.in_last && (k == plain.size() - 1);
        expected_bytes.push_back(e);
      end
      if (req.in_last) clear();
    endfunction

    function void check_result(out_req_t got);
      out_req_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_byte %h byte_valid %b string_end %b",
               got.out_byte, got.byte_valid, got.string_end);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.byte_valid !== want.byte_valid) begin
        $error("byte_valid: expected %b, got %b", want.byte_valid, got.byte_valid);
        errors++;
      end
      if (got.string_end !== want.string_end) begin
        $error("string_end: expected %b, got %b", want.string_end, got.string_end);
        errors++;
      end
    endfunction
  endclass

  typedef enum int {RX_STEADY, RX_SPARSE, RX_HALF, RX_EVERY4, RX_HOLD} rx_kind_t;
  typedef enum int {TOK_PRINT, TOK_BYTE, TOK_ESC, TOK_UNI, TOK_UNI_BAD, TOK_ESC_BAD} tok_t;

  localparam int RANDOM_ITEMS = 430;
  localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
                                              CH_F, CH_N, CH_R, CH_T};

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_ready;
  out_req_t out_data;

  unescape_checker unescape_chk;
  logic [7:0]      text_q[$];
  int              burst_left = 0;

  json_string_unescape dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Observe both channels on the edge that moves a request
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) unescape_chk.note_request(in_data);
      if (out_valid && out_ready) unescape_chk.check_result(out_data);
    end
  end

  // Offer one request, idling between bursts, and hold it until accepted
  task automatic send_request(input in_req_t req);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  // Send text_q as one string, last flag on its final byte
  task automatic send_text();
    in_req_t req;
    for (int k = 0; k < text_q.size(); k++) begin
      req.in_byte = text_q[k];
      req.in_last = (k == text_q.size() - 1);
      send_request(req);
    end
  endtask

  // Receiver: stall on changing patterns, with one long hold-off
  initial begin
    rx_kind_t kind;
    int       span;
    int       cycles;
    bit       held;
    cycles = 0;
    held   = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      kind = rx_kind_t'($urandom_range(0, 3));
      span = $urandom_range(8, 64);
      if (!held && cycles >= 150) begin
        held = 1'b1;
        kind = RX_HOLD;
        span = 160;
      end
      repeat (span) begin
        case (kind)
          RX_STEADY: out_ready <= 1'b1;
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) != 0);
          RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
          RX_EVERY4: out_ready <= (cycles % 4 == 0);
          default:   out_ready <= 1'b0;
        endcase
        cycles++;
        @(posedge clk);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int          sent;
    int          keep;
    int          ntok;
    int          bad_pos;
    tok_t        tok;
    logic [15:0] code;
    logic [3:0]  nib;
    logic [7:0]  ch;
    unescape_chk = new();
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // zero and high bytes pass, then every escape letter
    text_q = '{8'h00, 8'hFF, CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_BSLASH,
               CH_BSLASH, CH_SLASH, CH_BSLASH, CH_B, CH_BSLASH, CH_F,
               CH_BSLASH, CH_N, CH_BSLASH, CH_R, CH_BSLASH, CH_T};
    send_text();
    // three-byte code point, high byte as escape letter, lone backslash at end
    text_q = '{CH_BSLASH, CH_U, "F", "F", "F", "F", CH_BSLASH, 8'h80, CH_BSLASH};
    send_text();

    // random strings: mostly well-formed escapes, some broken, some noise
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      text_q.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        ntok = $urandom_range(1, 10);
        repeat (ntok) begin
          keep = $urandom_range(0, 99);
          if (keep < 30) tok = TOK_PRINT;
          else if (keep < 40) tok = TOK_BYTE;
          else if (keep < 60) tok = TOK_ESC;
          else if (keep < 85) tok = TOK_UNI;
          else if (keep < 92) tok = TOK_UNI_BAD;
          else tok = TOK_ESC_BAD;
          case (tok)
            TOK_PRINT: begin
              ch = 8'($urandom_range(8'h20, 8'h7E));
              text_q.push_back((ch == CH_BSLASH) ? CH_N : ch);
            end
            TOK_BYTE: text_q.push_back(8'($urandom_range(0, 255)));
            TOK_ESC: begin
              text_q.push_back(CH_BSLASH);
              text_q.push_back(ESC_LETTERS[$urandom_range(0, 7)]);
            end
            TOK_ESC_BAD: begin
              text_q.push_back(CH_BSLASH);
              text_q.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
              // pick a code point size class, then spell it in mixed case
              case ($urandom_range(0, 3))
                0: code = 16'h0000;
                1: code = 16'($urandom_range(16'h0001, 16'h007F));
                2: code = 16'($urandom_range(16'h0080, 16'h07FF));
                default: code = 16'($urandom_range(16'h0800, 16'hFFFF));
              endcase
              bad_pos = (tok == TOK_UNI_BAD) ? $urandom_range(0, 3) : -1;
              text_q.push_back(CH_BSLASH);
              text_q.push_back(CH_U);
              for (int d = 3; d >= 0; d--) begin
                nib = code[d*4 +: 4];
                if (nib < 4'd10) ch = "0" + {4'd0, nib};
                else ch = ($urandom_range(0, 1) ? "A" : "a") + {4'd0, nib} - 8'd10;
                if (d == bad_pos) ch = 8'($urandom_range(0, 255));
                text_q.push_back(ch);
              end
            end
          endcase
        end
        // cut some strings short so they may end inside an escape
        if ($urandom_range(0, 9) == 0) begin
          keep = $urandom_range(1, text_q.size());
          while (text_q.size() > keep) void'(text_q.pop_back());
        end
      end
      send_text();
      sent += text_q.size();
    end
    in_valid <= 1'b0;

    // drain outstanding results, then watch for strays
    @(posedge clk);
    while (unescape_chk.expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (unescape_chk.errors == 0 && unescape_chk.expected_bytes.size() == 0) begin
      $display("PASS json_string_unescape");
    end else begin
      $display("FAIL json_string_unescape");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("FAIL json_string_unescape");
    $finish;
  end

endmodule
